@@ sv/bprs_pkg.sv @@
// Package for the byte pattern range scanner: item types, register indexes,
// result kinds and the command and status groups between controller and datapath.
// No dependencies.
package bprs_pkg;

   // Width of the length registers.
   localparam int LEN_W = 5;
   localparam int CSR_IDX_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_LEN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_BUDGET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_LIMIT   = 3'd5;

   // Result kinds.
   localparam logic KIND_HIT     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [63:0] address;
      logic        start_scan;
      logic        first_of_range;
      logic        last_of_range;
      logic        last_of_scan;
      logic        readable;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [63:0] hit_address;
      logic        hit_full;
      logic [63:0] read_total;
      logic [63:0] unread_total;
      logic [31:0] range_total;
      logic [31:0] bad_range_total;
      logic        budget_stop;
      logic        cap_stop;
      logic        last_result;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic eval;
      logic end_item;
      logic push_summary;
      logic flush;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic eval_go;
      logic out_free;
      logic last_scan;
   } status_type;

endpackage

@@ sv/bprs_ctrl.sv @@
// Controller state machine of the byte pattern range scanner.
// Depends on bprs_pkg for the command and status groups.
module bprs_ctrl
   import bprs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EVAL  = 4'b0010,
      ST_SUMM  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.eval_go) begin
               if (status.out_free) begin
                  cmd.eval = 1'b1;
               end
            end else begin
               cmd.end_item = 1'b1;
               state_in     = status.last_scan ? ST_SUMM : ST_FLUSH;
            end
         end
         ST_SUMM: begin
            if (status.out_free) begin
               cmd.push_summary = 1'b1;
               state_in         = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/bprs_datapath.sv @@
// Datapath of the byte pattern range scanner: registers, window, counters,
// match logic, a staging register and the output register.
// Depends on bprs_pkg.
module bprs_datapath
   import bprs_pkg::*;
#(
   parameter int NEEDLE_MAX = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_write_data,
   input  req_item_type         req_data,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_item_type         rsp_data
);

   localparam int CNT_W = $clog2(NEEDLE_MAX + 1);
   localparam int IDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   // Configuration registers.
   logic [63:0]      needle_lo_ff, needle_hi_ff, budget_ff;
   logic [LEN_W-1:0] prefix_ff, nlen_ff;
   logic [15:0]      limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_lo_ff <= '0;
         needle_hi_ff <= '0;
         prefix_ff    <= LEN_W'(1);
         nlen_ff      <= LEN_W'(1);
         budget_ff    <= '0;
         limit_ff     <= 16'd1;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_NEEDLE_LOW:  needle_lo_ff <= csr_write_data;
            CSR_NEEDLE_HIGH: needle_hi_ff <= csr_write_data;
            CSR_PREFIX_LEN:  prefix_ff    <= csr_write_data[LEN_W-1:0];
            CSR_NEEDLE_LEN:  nlen_ff      <= csr_write_data[LEN_W-1:0];
            CSR_BYTE_BUDGET: budget_ff    <= csr_write_data;
            CSR_HIT_LIMIT:   limit_ff     <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Needle byte for each window slot; slots past the sixteenth compare with zero.
   logic [7:0] needle_byte [NEEDLE_MAX];
   for (genvar g = 0; g < NEEDLE_MAX; g++) begin : g_needle
      if (g < 8) begin : g_low
         assign needle_byte[g] = needle_lo_ff[8*g +: 8];
      end else if (g < 16) begin : g_high
         assign needle_byte[g] = needle_hi_ff[8*(g-8) +: 8];
      end else begin : g_zero
         assign needle_byte[g] = 8'd0;
      end
   end

   // Scan state.
   logic [7:0]       win_ff [NEEDLE_MAX];
   logic [7:0]       win_in [NEEDLE_MAX];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [63:0]      base_ff, base_in, len_ff, len_in;
   logic [63:0]      scanned_ff, scanned_in, unread_ff, unread_in;
   logic [31:0]      rsc_ff, rsc_in, rus_ff, rus_in;
   logic [15:0]      hits_ff, hits_in;
   logic [1:0]       rflags_ff, rflags_in, stop_ff, stop_in;
   logic             drain_all_ff, drain_all_in, range_end_ff, range_end_in;
   logic             last_scan_ff, last_scan_in;

   logic [CMP_W-1:0] cnt_ext, p_ext, n_ext;
   logic             valid_cfg, hit_ok, full_ok;
   logic [15:0]      hits_inc;

   assign cnt_ext   = CMP_W'(count_ff);
   assign p_ext     = CMP_W'(prefix_ff);
   assign n_ext     = CMP_W'(nlen_ff);
   assign valid_cfg = (prefix_ff != '0) && (prefix_ff <= nlen_ff) &&
                      (n_ext <= CMP_W'(NEEDLE_MAX)) && (limit_ff != '0);
   assign hits_inc  = hits_ff + 16'd1;

   // Prefix and full matches of the oldest pending start.
   always_comb begin
      hit_ok  = (cnt_ext >= p_ext);
      full_ok = (cnt_ext >= n_ext);
      for (int i = 0; i < NEEDLE_MAX; i++) begin
         if ((CMP_W'(i) < p_ext) && (win_ff[i] != needle_byte[i])) hit_ok = 1'b0;
         if ((CMP_W'(i) < n_ext) && (win_ff[i] != needle_byte[i])) full_ok = 1'b0;
      end
   end

   // An invalid configuration holds the window, so nothing is evaluated then.
   assign status.eval_go   = valid_cfg && (stop_ff == 2'b00) && (count_ff != '0) &&
                             (drain_all_ff || (cnt_ext >= n_ext));
   assign status.last_scan = last_scan_ff;

   // Next values of the scan state.
   always_comb begin
      win_in       = win_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      len_in       = len_ff;
      scanned_in   = scanned_ff;
      unread_in    = unread_ff;
      rsc_in       = rsc_ff;
      rus_in       = rus_ff;
      hits_in      = hits_ff;
      rflags_in    = rflags_ff;
      stop_in      = stop_ff;
      drain_all_in = drain_all_ff;
      range_end_in = range_end_ff;
      last_scan_in = last_scan_ff;

      if (cmd.accept) begin
         // A new scan clears the counters and stop flags.
         if (req_data.start_scan) begin
            scanned_in = '0;
            unread_in  = '0;
            rsc_in     = '0;
            rus_in     = '0;
            hits_in    = '0;
            stop_in    = '0;
         end
         if (req_data.start_scan || req_data.first_of_range) begin
            count_in  = '0;
            base_in   = '0;
            len_in    = '0;
            rflags_in = '0;
         end
         // Byte budget is checked before the byte is taken.
         if (valid_cfg && (stop_in == 2'b00) && (budget_ff != '0) &&
             (scanned_in >= budget_ff)) begin
            stop_in[0] = 1'b1;
            count_in   = '0;
         end
         drain_all_in = 1'b0;
         if (valid_cfg && (stop_in == 2'b00)) begin
            if (len_in != '1) len_in = len_in + 64'd1;
            if ((len_in >= 64'(prefix_ff)) && !rflags_in[0]) begin
               rflags_in[0] = 1'b1;
               if (rsc_in != '1) rsc_in = rsc_in + 32'd1;
            end
            if (req_data.readable) begin
               scanned_in = scanned_in + 64'd1;
               if (count_in < CNT_W'(NEEDLE_MAX)) begin
                  if (count_in == '0) base_in = req_data.address;
                  win_in[count_in[IDX_W-1:0]] = req_data.data_byte;
                  count_in = count_in + CNT_W'(1);
               end
            end else begin
               unread_in = unread_in + 64'd1;
               if (!rflags_in[1]) begin
                  rflags_in[1] = 1'b1;
                  if (rus_in != '1) rus_in = rus_in + 32'd1;
               end
            end
            drain_all_in = !req_data.readable || req_data.last_of_range ||
                           req_data.last_of_scan;
         end
         range_end_in = req_data.last_of_range || req_data.last_of_scan;
         last_scan_in = req_data.last_of_scan;
      end

      // Retire the oldest start; the hit cap empties the window instead.
      if (cmd.eval) begin
         if (hit_ok) hits_in = hits_inc;
         if (hit_ok && (hits_inc >= limit_ff)) begin
            stop_in[1] = 1'b1;
            count_in   = '0;
         end else begin
            for (int i = 0; i < NEEDLE_MAX - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[NEEDLE_MAX-1] = 8'd0;
            count_in = count_ff - CNT_W'(1);
            base_in  = base_ff + 64'd1;
         end
      end

      // Close the item: drained window empties, a range end resets the range.
      if (cmd.end_item) begin
         if (drain_all_ff || range_end_ff || (stop_ff != 2'b00)) count_in = '0;
         if (range_end_ff) begin
            base_in   = '0;
            len_in    = '0;
            rflags_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         count_ff     <= '0;
         base_ff      <= '0;
         len_ff       <= '0;
         scanned_ff   <= '0;
         unread_ff    <= '0;
         rsc_ff       <= '0;
         rus_ff       <= '0;
         hits_ff      <= '0;
         rflags_ff    <= '0;
         stop_ff      <= '0;
         drain_all_ff <= 1'b0;
         range_end_ff <= 1'b0;
         last_scan_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         base_ff      <= base_in;
         len_ff       <= len_in;
         scanned_ff   <= scanned_in;
         unread_ff    <= unread_in;
         rsc_ff       <= rsc_in;
         rus_ff       <= rus_in;
         hits_ff      <= hits_in;
         rflags_ff    <= rflags_in;
         stop_ff      <= stop_in;
         drain_all_ff <= drain_all_in;
         range_end_ff <= range_end_in;
         last_scan_ff <= last_scan_in;
      end
   end

   // Result items: a staging register holds the newest item until it is known
   // whether another follows, so that the last one of each input can be marked.
   rsp_item_type hit_res, summ_res, new_res, stg_ff, stg_in, out_ff, out_in;
   logic         stg_valid_ff, stg_valid_in, out_valid_ff, out_valid_in, push;

   always_comb begin
      hit_res             = '0;
      hit_res.result_kind = KIND_HIT;
      hit_res.hit_address = base_ff;
      hit_res.hit_full    = full_ok;

      summ_res                 = '0;
      summ_res.result_kind     = KIND_SUMMARY;
      summ_res.read_total      = scanned_ff;
      summ_res.unread_total    = unread_ff;
      summ_res.range_total     = rsc_ff;
      summ_res.bad_range_total = rus_ff;
      summ_res.budget_stop     = stop_ff[0];
      summ_res.cap_stop        = stop_ff[1];
   end

   assign push    = (cmd.eval && hit_ok) || cmd.push_summary;
   assign new_res = cmd.push_summary ? summ_res : hit_res;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      stg_in       = stg_ff;
      stg_valid_in = stg_valid_ff;
      if (push) begin
         if (stg_valid_ff) begin
            out_in       = stg_ff;
            out_valid_in = 1'b1;
         end
         stg_in       = new_res;
         stg_valid_in = 1'b1;
      end
      if (cmd.flush && stg_valid_ff) begin
         out_in             = stg_ff;
         out_in.last_result = 1'b1;
         out_valid_in       = 1'b1;
         stg_valid_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      stg_ff <= stg_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
         stg_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_data        = out_ff;

endmodule

@@ sv/byte_pattern_range_scanner_top.sv @@
// Top level of the byte pattern range scanner.
// Depends on bprs_pkg, bprs_ctrl and bprs_datapath.
//
// Memory bytes arrive on the req_ channel, one item per byte, with address and
// range and scan marks. Every start address whose first prefix_length bytes
// equal the needle yields a hit item on the rsp_ channel, in ascending order;
// the last byte of a scan also yields a summary item of the counters. The last
// item caused by an input carries last_result.
// Registers are written on the csr_ port whenever csr_write_en is high; the user
// must write them only while the block is idle, which the block does not enforce.
// One input item is handled at a time. Each item passes through acceptance, the
// evaluation of pending starts (at most one for an ordinary byte, up to NEEDLE_MAX
// at a range end and up to NEEDLE_MAX-1 at an unreadable byte), a summary step at
// the end of a scan and a flush step. Evaluation of the window handles one start
// per cycle while the output register is free. The first result moves from the
// staging register to the output register when another follows it, or at flush.
// When the receiver stalls, results wait in the output and staging registers
// and evaluation pauses. Synchronous reset returns registers to their reset
// values, empties the window and clears all counters.
module byte_pattern_range_scanner_top
   import bprs_pkg::*;
#(
   parameter int NEEDLE_MAX = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_item_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_item_type         rsp_data
);

   cmd_type    cmd;
   status_type status;

   // Sequencing of each item.
   bprs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Window, counters and result registers.
   bprs_datapath #(
      .NEEDLE_MAX (NEEDLE_MAX)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_data       (req_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule

@@ test/byte_pattern_range_scanner_top_test.sv @@
// Self-checking testbench for byte_pattern_range_scanner_top.
// Depends on bprs_pkg and the scanner RTL; drives a directed table, extreme settings, then random scans.
module byte_pattern_range_scanner_top_test;
   import bprs_pkg::*;

   localparam int NMAX      = 16;
   localparam int CYCLE_CAP = 400000;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_write_data;
   logic                 req_valid;
   logic                 req_ready;
   req_item_type         req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_item_type         rsp_data;

   byte_pattern_range_scanner_top i_dut (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Clock with a period of 20.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Shadow copy of the registers and the scanner state.
   logic [63:0] needle_lo, needle_hi, budget;
   logic [4:0]  pre_len, ndl_len;
   logic [15:0] hit_cap;
   logic [7:0]  win_byte [NMAX];
   logic        win_ok   [NMAX];
   logic [63:0] win_base, run_len, n_scanned, n_unread;
   logic [31:0] n_rng_scan, n_rng_unread;
   logic [15:0] n_hits;
   logic [1:0]  rng_flags, stop_flags;

   rsp_item_type expected_rsps[$];
   int  errors;
   int  cycles;
   bit  rsp_stall_mode;

   function automatic logic [7:0] needle_byte(int i);
      if (i < 8) return needle_lo[8*i +: 8];
      if (i < 16) return needle_hi[8*(i-8) +: 8];
      return 8'd0;
   endfunction

   function automatic int window_fill();
      int c;
      c = 0;
      while (c < NMAX && win_ok[c]) c++;
      return c;
   endfunction

   function automatic void empty_window();
      for (int i = 0; i < NMAX; i++) begin
         win_byte[i] = 8'd0;
         win_ok[i]   = 1'b0;
      end
   endfunction

   function automatic void forget_range();
      empty_window();
      win_base  = '0;
      run_len   = '0;
      rng_flags = '0;
   endfunction

   function automatic void queue_hit(logic [63:0] addr, logic full);
      rsp_item_type r;
      r = '0;
      r.result_kind = KIND_HIT;
      r.hit_address = addr;
      r.hit_full    = full;
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   function automatic void queue_summary();
      rsp_item_type r;
      r = '0;
      r.result_kind     = KIND_SUMMARY;
      r.read_total      = n_scanned;
      r.unread_total    = n_unread;
      r.range_total     = n_rng_scan;
      r.bad_range_total = n_rng_unread;
      r.budget_stop     = stop_flags[0];
      r.cap_stop        = stop_flags[1];
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   // Judge the oldest pending start on the bytes present, then retire it.
   function automatic void judge_oldest();
      int  c;
      bit  hit, full;
      c = window_fill();
      if (c == 0) return;
      hit = (c >= pre_len);
      for (int i = 0; hit && i < pre_len && i < NMAX; i++)
         if (win_byte[i] != needle_byte(i)) hit = 0;
      if (hit) begin
         full = (c >= ndl_len);
         for (int i = 0; full && i < ndl_len && i < NMAX; i++)
            if (win_byte[i] != needle_byte(i)) full = 0;
         queue_hit(win_base, full);
         n_hits = n_hits + 16'd1;
         if (n_hits >= hit_cap) begin
            stop_flags[1] = 1'b1;
            empty_window();
            return;
         end
      end
      for (int i = 0; i < NMAX - 1; i++) begin
         win_byte[i] = win_byte[i+1];
         win_ok[i]   = win_ok[i+1];
      end
      win_byte[NMAX-1] = 8'd0;
      win_ok[NMAX-1]   = 1'b0;
      win_base = win_base + 64'd1;
   endfunction

   function automatic void flush_window();
      while (stop_flags == 2'b00 && window_fill() > 0) judge_oldest();
      empty_window();
   endfunction

   function automatic void set_register(logic [CSR_IDX_W-1:0] idx, logic [63:0] v);
      case (idx)
         CSR_NEEDLE_LOW:  needle_lo = v;
         CSR_NEEDLE_HIGH: needle_hi = v;
         CSR_PREFIX_LEN:  pre_len   = v[4:0];
         CSR_NEEDLE_LEN:  ndl_len   = v[4:0];
         CSR_BYTE_BUDGET: budget    = v;
         CSR_HIT_LIMIT:   hit_cap   = v[15:0];
         default: ;
      endcase
   endfunction

   // Predict the results of one accepted byte; returns how many were queued.
   function automatic int predict_scan(req_item_type it);
      bit cfg_ok, range_end;
      int n_prior, c;
      n_prior = expected_rsps.size();
      cfg_ok = pre_len >= 1 && pre_len <= ndl_len && ndl_len <= NMAX && hit_cap != 0;
      range_end = it.last_of_range || it.last_of_scan;
      if (it.start_scan) begin
         n_scanned = '0; n_unread = '0; n_rng_scan = '0; n_rng_unread = '0;
         n_hits = '0; stop_flags = '0;
         forget_range();
      end
      if (it.first_of_range) forget_range();
      if (cfg_ok && stop_flags == 0 && budget != 0 && n_scanned >= budget) begin
         stop_flags[0] = 1'b1;
         empty_window();
      end
      if (cfg_ok && stop_flags == 0) begin
         if (run_len != '1) run_len = run_len + 64'd1;
         if (run_len >= pre_len && !rng_flags[0]) begin
            rng_flags[0] = 1'b1;
            if (n_rng_scan != '1) n_rng_scan++;
         end
         if (it.readable) begin
            c = window_fill();
            n_scanned = n_scanned + 64'd1;
            if (c < NMAX) begin
               if (c == 0) win_base = it.address;
               win_byte[c] = it.data_byte;
               win_ok[c]   = 1'b1;
            end
            while (stop_flags == 0 && window_fill() >= ndl_len) judge_oldest();
         end else begin
            n_unread = n_unread + 64'd1;
            if (!rng_flags[1]) begin
               rng_flags[1] = 1'b1;
               if (n_rng_unread != '1) n_rng_unread++;
            end
            flush_window();
         end
         if (range_end) flush_window();
      end
      if (stop_flags != 0) empty_window();
      if (range_end) forget_range();
      if (it.last_of_scan) queue_summary();
      if (expected_rsps.size() > n_prior)
         expected_rsps[expected_rsps.size()-1].last_result = 1'b1;
      return expected_rsps.size() - n_prior;
   endfunction

   // Receiver: stalls on its own pattern; compares every accepted result.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: unexpected result %h", $time, rsp_data);
            end else begin
               rsp_item_type e;
               e = expected_rsps.pop_front();
               if (e !== rsp_data) begin
                  errors++;
                  $display("%0t: result mismatch expected %h actual %h", $time, e, rsp_data);
               end
            end
         end
         if (rsp_stall_mode) rsp_ready <= ($urandom_range(3) != 0);
         else rsp_ready <= 1'b1;
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   int burst_left;

   // Send one byte; a random gap comes ahead of each burst of bytes.
   task automatic send_byte(req_item_type it);
      if (burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         repeat ($urandom_range(4)) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      void'(predict_scan(it));
      req_valid <= 1'b0;
      // The block is busy in its evaluate and flush states after it takes an item.
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [63:0] v);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= v;
      @(posedge clock);
      set_register(idx, v);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_item_type make_byte(logic [7:0] d, logic [63:0] a, bit s, bit f,
                                              bit lr, bit ls, bit rd);
      req_item_type it;
      it.data_byte = d; it.address = a; it.start_scan = s; it.first_of_range = f;
      it.last_of_range = lr; it.last_of_scan = ls; it.readable = rd;
      return it;
   endfunction

   // Directed table: a few rows carry the summary typed in by hand.
   typedef struct {
      req_item_type stim;
      bit           has_summary;
      logic [63:0]  sum_scanned;
      logic [63:0]  sum_unread;
   } table_row_type;

   table_row_type rows[$];

   task automatic add_row(req_item_type it, bit hs, logic [63:0] sc, logic [63:0] un);
      table_row_type r;
      r.stim = it; r.has_summary = hs; r.sum_scanned = sc; r.sum_unread = un;
      rows.insert(rows.size(), r);
   endtask

   // A random scan: ranges, mostly built to contain the needle.
   task automatic random_scan(int nbytes);
      logic [63:0] addr;
      int  pos, rng_left;
      bit  first;
      addr = {$urandom, $urandom};
      rng_left = 0;
      for (int k = 0; k < nbytes; k++) begin
         req_item_type it;
         first = 0;
         if (rng_left == 0) begin
            rng_left = $urandom_range(20, 1);
            first = ($urandom_range(9) != 0);
            pos = 0;
            addr = {$urandom, $urandom};
         end
         if ($urandom_range(2) == 0) pos = 0;
         it.data_byte = ($urandom_range(9) < 7) ? needle_byte(pos % ndl_len) : 8'($urandom);
         pos++;
         it.address = addr;
         it.start_scan = (k == 0) || ($urandom_range(150) == 0);
         it.first_of_range = first;
         it.last_of_range = (rng_left == 1) && ($urandom_range(7) != 0);
         it.last_of_scan = (k == nbytes - 1) || ($urandom_range(80) == 0);
         it.readable = ($urandom_range(19) != 0);
         addr = addr + 64'd1;
         rng_left--;
         send_byte(it);
      end
   endtask

   initial begin
      logic [63:0] v;
      errors = 0; cycles = 0; burst_left = 0; rsp_stall_mode = 0;
      reset = 1'b1;
      csr_write_en = 1'b0; csr_index = '0; csr_write_data = '0;
      req_valid = 1'b0; req_data = '0;
      needle_lo = '0; needle_hi = '0; budget = '0; pre_len = 5'd1; ndl_len = 5'd1;
      hit_cap = 16'd1;
      forget_range();
      n_scanned = '0; n_unread = '0; n_rng_scan = '0; n_rng_unread = '0;
      n_hits = '0; stop_flags = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset settings: needle zero, one byte, one hit allowed.
      // The first byte hits and reaches the cap, so the second is ignored.
      add_row(make_byte(8'h00, 64'h0, 1, 1, 0, 0, 1), 0, 0, 0);
      add_row(make_byte(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 0, 1, 1), 1, 1, 0);
      add_row(make_byte(8'h55, 64'h10, 1, 1, 1, 1, 0), 1, 0, 1);
      foreach (rows[i]) begin
         send_byte(rows[i].stim);
         if (rows[i].has_summary) begin
            rsp_item_type s;
            s = expected_rsps[expected_rsps.size()-1];
            if (s.read_total !== rows[i].sum_scanned ||
                s.unread_total !== rows[i].sum_unread) begin
               errors++;
               $display("%0t: table summary expected %0d/%0d actual %0d/%0d", $time,
                        rows[i].sum_scanned, rows[i].sum_unread,
                        s.read_total, s.unread_total);
            end
         end
      end
      wait_idle();

      // Extreme settings: full sixteen-byte needle, invalid config, budget of one.
      write_register(CSR_NEEDLE_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      write_register(CSR_NEEDLE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      write_register(CSR_NEEDLE_LEN, 64'd16);
      write_register(CSR_PREFIX_LEN, 64'd16);
      write_register(CSR_HIT_LIMIT, 64'hFFFF);
      for (int k = 0; k < 20; k++)
         send_byte(make_byte(8'hFF, 64'hFFFF_FFFF_FFFF_FFF0 + k, k == 0, k == 0, 0, k == 19, 1));
      wait_idle();
      write_register(CSR_PREFIX_LEN, 64'd0);
      send_byte(make_byte(8'hFF, 64'h0, 1, 1, 0, 1, 1));
      wait_idle();
      write_register(CSR_PREFIX_LEN, 64'd1);
      write_register(CSR_BYTE_BUDGET, 64'd1);
      for (int k = 0; k < 3; k++)
         send_byte(make_byte(8'hFF, 64'h100 + k, k == 0, k == 0, 0, k == 2, 1));
      wait_idle();

      // Random phases under a range of settings.
      for (int ph = 0; ph < 8; ph++) begin
         int nl;
         rsp_stall_mode = ph[0];
         nl = (ph == 7) ? 16 : $urandom_range(16, 1);
         write_register(CSR_NEEDLE_LOW, {$urandom, $urandom});
         write_register(CSR_NEEDLE_HIGH, {$urandom, $urandom});
         write_register(CSR_NEEDLE_LEN, 64'(nl));
         write_register(CSR_PREFIX_LEN, 64'($urandom_range(nl, 1)));
         v = (ph % 3 == 0) ? 64'($urandom_range(60, 5)) : 64'd0;
         write_register(CSR_BYTE_BUDGET, v);
         v = (ph == 5) ? 64'd0 : ((ph % 2) ? 64'hFFFF : 64'($urandom_range(12, 1)));
         write_register(CSR_HIT_LIMIT, v);
         random_scan(50);
         wait_idle();
      end

      wait_idle();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
